@@ hdl/ttc_pkg.sv @@
package ttc_pkg;

  // Store geometry
  localparam int LINES  = 256;
  localparam int COLS   = 128;
  localparam int SLOT_W = $clog2(LINES);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int CELL_W = 8;

  // Counter widths
  localparam int TOT_W  = $clog2(LINES + 1);
  localparam int VS_W   = $clog2(2 * LINES);
  localparam int LN_W   = VS_W + 1;
  localparam int ROW_W  = 8;
  localparam int RCNT_W = 9;
  localparam int CCNT_W = 8;

  // Limits
  localparam int VS_MAX   = 2 * LINES - 1;
  localparam int COLS_LIM = (COLS < 128) ? COLS : 128;
  localparam int ROWS_LIM = 256;
  localparam int TAB_STEP = 8;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;
  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [8:0] ROWS_RST = 9'd24;

  // Byte codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_LAST  = 8'd127;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_in;
    logic [7:0] read_row;
    logic [6:0] read_col;
  } ttc_in_t;

  typedef struct packed {
    logic [7:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic [7:0] shown_top;
    logic [8:0] lines_held;
    logic [7:0] cell_data;
    logic       row_valid;
  } ttc_out_t;

  // Status from the sequencer to the result stage
  typedef struct packed {
    logic              fire;
    logic              rd;
    logic              row_ok;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [VS_W-1:0]   view_start;
    logic [TOT_W-1:0]  line_total;
    logic [RCNT_W-1:0] rows;
  } ttc_stat_t;

endpackage

@@ hdl/ttc_ram.sv @@
module ttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ttc_seq.sv @@
module ttc_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  ttc_pkg::ttc_in_t                in_data,
  input  logic                            cfg_we,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttc_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            busy,
  output logic                            mem_we,
  output logic [ttc_pkg::ADDR_W-1:0]      mem_waddr,
  output logic [ttc_pkg::CELL_W-1:0]      mem_wdata,
  output logic [ttc_pkg::ADDR_W-1:0]      mem_raddr,
  output ttc_pkg::ttc_stat_t              stat
);
  import ttc_pkg::*;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [7:0]        cols_r;
  logic [8:0]        rows_r;
  logic [SLOT_W-1:0] ring_base_r, ring_base_nxt;
  logic [TOT_W-1:0]  line_total_r, line_total_nxt;
  logic [VS_W-1:0]   view_start_r, view_start_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [SLOT_W-1:0] clr_slot_r, clr_slot_nxt;
  logic [COL_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              rd_r, rd_nxt;
  logic              row_ok_r, row_ok_nxt;
  logic [7:0]        byte_r, byte_nxt;

  logic [CCNT_W-1:0] ecols, ecols_m1;
  logic [RCNT_W-1:0] erows, erows_m1;
  logic [RCNT_W-1:0] row_inc;
  logic [ROW_W-1:0]  nr_row;
  logic [VS_W-1:0]   nr_vs;
  logic [LN_W-1:0]   line_w, tot_ext, line_c;
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  logic [CCNT_W-1:0] tab_sum, tab_col, col_ext, col_inc;
  logic              accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  // Clamp the configured sizes
  always_comb begin
    if (cols_r == '0) begin
      ecols = CCNT_W'(1);
    end else if (cols_r > CCNT_W'(COLS_LIM)) begin
      ecols = CCNT_W'(COLS_LIM);
    end else begin
      ecols = cols_r;
    end
    if (rows_r == '0) begin
      erows = RCNT_W'(1);
    end else if (rows_r > RCNT_W'(ROWS_LIM)) begin
      erows = RCNT_W'(ROWS_LIM);
    end else begin
      erows = rows_r;
    end
    ecols_m1 = ecols - CCNT_W'(1);
    erows_m1 = erows - RCNT_W'(1);
  end

  // Line feed: advance the row, scroll the view at the last row
  always_comb begin
    row_inc = {1'b0, cur_row_r} + RCNT_W'(1);
    if (row_inc >= erows) begin
      nr_row = erows_m1[ROW_W-1:0];
      nr_vs  = (view_start_r < VS_W'(VS_MAX)) ? view_start_r + VS_W'(1) : view_start_r;
    end else begin
      nr_row = row_inc[ROW_W-1:0];
      nr_vs  = view_start_r;
    end
  end

  // Cursor line and ring slots
  always_comb begin
    line_w  = {1'b0, view_start_r} + {{(LN_W-ROW_W){1'b0}}, cur_row_r};
    tot_ext = {{(LN_W-TOT_W){1'b0}}, line_total_r};
    line_c  = (line_w >= tot_ext) ? tot_ext - LN_W'(1) : line_w;
    wr_slot = ring_base_r + line_c[SLOT_W-1:0];
    rd_slot = ring_base_r + in_data.read_row[SLOT_W-1:0];
    col_ext = {1'b0, cur_col_r};
    col_inc = col_ext + CCNT_W'(1);
    tab_sum = col_ext + CCNT_W'(TAB_STEP);
    tab_col = {tab_sum[CCNT_W-1:3], 3'b000};
  end

  assign mem_raddr = {rd_slot, in_data.read_col};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    ring_base_nxt  = ring_base_r;
    line_total_nxt = line_total_r;
    view_start_nxt = view_start_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    clr_slot_nxt   = clr_slot_r;
    clr_cnt_nxt    = clr_cnt_r;
    rd_nxt         = rd_r;
    row_ok_nxt     = row_ok_r;
    byte_nxt       = byte_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    case (state_r)
      ST_INIT: begin
        // Clear line 0 after reset
        mem_we      = 1'b1;
        mem_waddr   = {SLOT_W'(0), clr_cnt_r};
        clr_cnt_nxt = clr_cnt_r + COL_W'(1);
        if (clr_cnt_r == COL_W'(COLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_nxt     = in_data.req_type;
          row_ok_nxt = {1'b0, in_data.read_row} < line_total_r;
          byte_nxt   = in_data.byte_in;
          state_nxt  = ST_FIN;
          if (!in_data.req_type) begin
            case (in_data.byte_in)
              CH_LF: begin
                cur_col_nxt    = '0;
                cur_row_nxt    = nr_row;
                view_start_nxt = nr_vs;
              end
              CH_CR: begin
                cur_col_nxt = '0;
              end
              CH_TAB: begin
                if (tab_col >= ecols) begin
                  cur_col_nxt = ecols_m1[COL_W-1:0];
                end else begin
                  cur_col_nxt = tab_col[COL_W-1:0];
                end
              end
              CH_BS: begin
                if (cur_col_r != '0) begin
                  cur_col_nxt = cur_col_r - COL_W'(1);
                end
              end
              default: begin
                if (in_data.byte_in >= CH_FIRST && in_data.byte_in <= CH_LAST) begin
                  state_nxt = ST_CHK;
                end
              end
            endcase
          end
        end
      end
      ST_CHK: begin
        if (line_w >= tot_ext && line_total_r < TOT_W'(LINES)) begin
          // Append a fresh line
          clr_slot_nxt   = ring_base_r + line_total_r[SLOT_W-1:0];
          line_total_nxt = line_total_r + TOT_W'(1);
          clr_cnt_nxt    = '0;
          state_nxt      = ST_CLR;
        end else if (line_w >= tot_ext && view_start_r != '0) begin
          // Store full: recycle the oldest line as the newest
          clr_slot_nxt   = ring_base_r;
          ring_base_nxt  = ring_base_r + SLOT_W'(1);
          view_start_nxt = view_start_r - VS_W'(1);
          clr_cnt_nxt    = '0;
          state_nxt      = ST_CLR;
        end else begin
          // Write the character and advance, wrapping at the last column
          if (col_ext < ecols) begin
            mem_we    = 1'b1;
            mem_waddr = {wr_slot, cur_col_r};
            mem_wdata = byte_r;
            if (col_inc >= ecols) begin
              cur_col_nxt    = '0;
              cur_row_nxt    = nr_row;
              view_start_nxt = nr_vs;
            end else begin
              cur_col_nxt = col_inc[COL_W-1:0];
            end
          end else begin
            cur_col_nxt    = '0;
            cur_row_nxt    = nr_row;
            view_start_nxt = nr_vs;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = {clr_slot_r, clr_cnt_r};
        clr_cnt_nxt = clr_cnt_r + COL_W'(1);
        if (clr_cnt_r == COL_W'(COLS - 1)) begin
          state_nxt = ST_CHK;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      ring_base_r  <= '0;
      line_total_r <= TOT_W'(1);
      view_start_r <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      clr_cnt_r    <= '0;
      rd_r         <= 1'b0;
      row_ok_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ring_base_r  <= ring_base_nxt;
      line_total_r <= line_total_nxt;
      view_start_r <= view_start_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      rd_r         <= rd_nxt;
      row_ok_r     <= row_ok_nxt;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    clr_slot_r <= clr_slot_nxt;
    byte_r     <= byte_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_r <= cfg_wdata[7:0];
        CFG_ROWS: rows_r <= cfg_wdata[8:0];
        default: begin
          cols_r <= cols_r;
        end
      endcase
    end
  end

  always_comb begin
    stat.fire       = (state_r == ST_FIN);
    stat.rd         = rd_r;
    stat.row_ok     = row_ok_r;
    stat.cur_row    = cur_row_r;
    stat.cur_col    = cur_col_r;
    stat.view_start = view_start_r;
    stat.line_total = line_total_r;
    stat.rows       = erows;
  end

endmodule

@@ hdl/ttc_out.sv @@
module ttc_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttc_pkg::ttc_stat_t          stat,
  input  logic [ttc_pkg::CELL_W-1:0]  rdata,
  output logic                        out_strobe,
  output ttc_pkg::ttc_out_t           out_data
);
  import ttc_pkg::*;

  logic              out_strobe_r;
  ttc_out_t          out_data_r, out_data_nxt;
  logic [LN_W-1:0]   win_end, tot_ext, rows_ext;
  logic [LN_W-1:0]   top;

  // Lower the view start so the window ends at the last held line
  always_comb begin
    win_end  = {1'b0, stat.view_start} + {{(LN_W-RCNT_W){1'b0}}, stat.rows};
    tot_ext  = {{(LN_W-TOT_W){1'b0}}, stat.line_total};
    rows_ext = {{(LN_W-RCNT_W){1'b0}}, stat.rows};
    if (win_end > tot_ext) begin
      top = (tot_ext > rows_ext) ? tot_ext - rows_ext : '0;
    end else begin
      top = {1'b0, stat.view_start};
    end
  end

  // Assemble the result transaction
  always_comb begin
    out_data_nxt.cursor_row_out = stat.cur_row;
    out_data_nxt.cursor_col_out = stat.cur_col;
    out_data_nxt.shown_top      = top[7:0];
    out_data_nxt.lines_held     = stat.line_total;
    out_data_nxt.row_valid      = stat.rd && stat.row_ok;
    out_data_nxt.cell_data      = (stat.rd && stat.row_ok) ? rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= stat.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

@@ hdl/text_terminal_cursor_engine.sv @@
// Control bytes and cell reads go straight to the finish state, whose result strobe is registered.
// Printable bytes pass the check state too; each line appended or recycled adds a clear-state pass.
// The sequencer takes a new transaction only when idle, never before the last one has finished.
// Reset: synchronous, active low; afterwards busy stays high while line 0 is cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module text_terminal_cursor_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ttc_pkg::ttc_in_t                in_data,
  output logic                            out_strobe,
  output ttc_pkg::ttc_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttc_pkg::CFG_W-1:0]       cfg_wdata
);
  import ttc_pkg::*;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;
  ttc_stat_t         stat;

  ttc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .stat      (stat)
  );

  ttc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (LINES * COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ttc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .rdata      (mem_rdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  // Every accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a transaction");

  // Results never come in consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // The store always holds between one and LINES lines
  a_lines_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.lines_held != '0) && (out_data.lines_held <= LINES))
    else $error("lines_held out of range");

  // A cell read never reports a row beyond the held lines
  a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.row_valid |-> out_data.cell_data == '0)
    else $error("cell data reported for an invalid row");
`endif

endmodule
